// ----- src/bsenc_pkg.sv -----
package bsenc_pkg;

   // Depth of the item queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;

   // Bit budget in units of 2^-24 bit.
   localparam int BUDGET_W = 31;
   localparam logic signed [BUDGET_W-1:0] BUDGET_LIMIT  = 31'sd402653175;
   localparam logic signed [BUDGET_W-1:0] BITS_PER_CHAR = 31'sd109447194;
   localparam logic signed [BUDGET_W-1:0] BITS_PER_BYTE = 31'sd134217725;
   localparam logic signed [BUDGET_W-1:0] BUDGET_MAX    = 31'sd536870900;

   localparam int ACC_W  = 32;
   localparam int CHAR_W = 7;
   localparam logic [CHAR_W-1:0] RADIX = 7'd92;

   // x / 92 == (x >> 2) / 23; for a 30-bit y, y / 23 == (y * MAGIC) >> 35.
   localparam int DIV_IN_W  = 30;
   localparam int MAGIC_W   = 31;
   localparam int PROD_W    = DIV_IN_W + MAGIC_W;
   localparam int DIV_SHIFT = 35;
   localparam int QUOT_W    = PROD_W - DIV_SHIFT;
   localparam logic [MAGIC_W-1:0] DIV23_MAGIC = 31'd1493901669;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRE,
      ST_MUL,
      ST_EMIT
   } state_type;

   // Alphabet is ASCII 33..126 without '.' and '/'.
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [CHAR_W-1:0] d);
      return (d < 7'd13) ? (7'd33 + d) : (7'd35 + d);
   endfunction

endpackage

// ----- src/bsenc_front.sv -----
module bsenc_front #(
   parameter int unsigned Depth = bsenc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bsenc_pkg::item_type req_item,
   output logic               item_valid,
   input  logic               item_pop,
   output bsenc_pkg::item_type item
);
   import bsenc_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   item_type            queue_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                push, pop;

   assign req_ready  = (count_ff != CntW'(Depth));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   assign push = req_valid && req_ready;
   assign pop  = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ----- src/bsenc_back.sv -----
module bsenc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  bsenc_pkg::item_type item,
   output logic                item_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [6:0]          rsp_char,
   output logic                rsp_last
);
   import bsenc_pkg::*;

   state_type                    state_ff, state_in;
   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic signed [BUDGET_W-1:0]   budget_ff, budget_in;
   logic [7:0]                   byte_ff, byte_in;
   logic                         eom_ff, eom_in;
   logic                         flush_ff, flush_in;
   logic [PROD_W-1:0]            prod_ff, prod_in;
   logic                         out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]            out_char_ff, out_char_in;
   logic                         out_last_ff, out_last_in;

   logic [QUOT_W-1:0]            quot;
   logic [ACC_W-1:0]             quot_ext, quot_x92, rem_full;
   logic signed [BUDGET_W-1:0]   budget_dec;
   logic                         out_free;

   assign rsp_valid = out_valid_ff;
   assign rsp_char  = out_char_ff;
   assign rsp_last  = out_last_ff;

   // Quotient from the registered product; 92 = 64 + 16 + 8 + 4.
   assign quot       = prod_ff[PROD_W-1:DIV_SHIFT];
   assign quot_ext   = ACC_W'(quot);
   assign quot_x92   = (quot_ext << 6) + (quot_ext << 4) + (quot_ext << 3) + (quot_ext << 2);
   assign rem_full   = acc_ff - quot_x92;
   assign budget_dec = budget_ff - BITS_PER_CHAR;
   assign out_free   = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      budget_in    = budget_ff;
      byte_in      = byte_ff;
      eom_in       = eom_ff;
      flush_in     = flush_ff;
      prod_in      = prod_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      item_pop     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            item_pop = item_valid;
            if (item_valid) begin
               byte_in  = item.data_byte;
               eom_in   = item.end_of_message;
               state_in = ST_PRE;
            end
         end
         ST_PRE: begin
            if (budget_ff > BUDGET_LIMIT) begin
               // surplus over 24 bits: work it off before the shift
               flush_in = 1'b0;
               state_in = ST_MUL;
            end else begin
               budget_in = budget_ff + BITS_PER_BYTE;
               acc_in    = {acc_ff[ACC_W-9:0], byte_ff};
               flush_in  = eom_ff;
               state_in  = eom_ff ? ST_MUL : ST_IDLE;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(acc_ff[ACC_W-1:2]) * PROD_W'(DIV23_MAGIC);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = digit_to_ascii(rem_full[CHAR_W-1:0]);
               out_last_in  = flush_ff && (budget_dec <= 0);
               acc_in       = quot_ext;
               budget_in    = budget_dec;
               if (!flush_ff) begin
                  state_in = ST_PRE;
               end else if (budget_dec > 0) begin
                  state_in = ST_MUL;
               end else begin
                  // end of message: back to the reset state
                  acc_in    = '0;
                  budget_in = '0;
                  flush_in  = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         budget_ff    <= '0;
         flush_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         budget_ff    <= budget_in;
         flush_ff     <= flush_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      eom_ff      <= eom_in;
      prod_ff     <= prod_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   a_budget_bound: assert property (@(posedge clock) disable iff (reset)
      budget_ff <= BUDGET_MAX)
      else $error("bit budget above its bound");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> rem_full < ACC_W'(RADIX))
      else $error("remainder not below the radix");

   a_flush_positive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && flush_ff) |-> budget_ff > 0)
      else $error("flush step with empty budget");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && flush_ff && budget_dec <= 0)
      |=> (state_ff == ST_IDLE && acc_ff == '0 && budget_ff == '0 && rsp_last))
      else $error("state not cleared after last character");

endmodule

// ----- src/base92_stream_encoder.sv -----
// Base-92 stream encoder.
// Input channel req_*: one message byte per item, req_tlast marks the final byte
// of a message. Output channel rsp_*: one ASCII character per item, least
// significant digit first, rsp_tlast on the final character of the message.
// A byte enters a short queue (front) and is worked off by a sequencer (back)
// that divides the accumulator by 92 with a registered reciprocal multiply.
// A flush character takes a multiply step, then a remainder and emit step; a
// character worked off before the shift adds a budget check in front of them.
// A byte is popped and then shifted in, after at most two characters are
// worked off before the shift; the final byte is then followed by flush
// characters (at most five).
// The queue keeps req_tready high while the back end is busy, until it fills.
// When rsp_tready is low the character waits in the output register and the
// back end stalls in its emit step; no item is lost or repeated.
// Reset (synchronous, active high) empties the queue and the output register
// and clears the accumulator and bit budget; the block is ready the next cycle.
module base92_stream_encoder #(
   parameter int unsigned QueueDepth = bsenc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] out_char, [7] zero
   output logic       rsp_tlast    // last_char
);
   import bsenc_pkg::*;

   item_type          req_item;
   item_type          queue_item;
   logic              queue_valid;
   logic              queue_pop;
   logic [CHAR_W-1:0] rsp_char;

   assign req_item.data_byte      = req_tdata;
   assign req_item.end_of_message = req_tlast;

   bsenc_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .item_valid (queue_valid),
      .item_pop   (queue_pop),
      .item       (queue_item)
   );

   bsenc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (queue_item),
      .item_pop   (queue_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_char   (rsp_char),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_char};

endmodule
